/* sv/scpa_pkg.sv */
// ============================================================================
// scpa_pkg - shared types and constants for the size-class pool allocator
// Field widths, stream packing, register map, command and status codes.
// ============================================================================
package scpa_pkg;

    // Payload field widths
    localparam int CMD_W      = 1;
    localparam int SIZE_W     = 8;
    localparam int ADDR_W     = 14;
    localparam int STATUS_W   = 2;
    localparam int CNT_REG_W  = 5;

    // Stream data widths, rounded up to whole bytes
    localparam int S_TDATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W  = ((ADDR_W + STATUS_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W      = 8;
    localparam int CFG_DATA_W     = 8;
    localparam int CFG_CLASSES    = 4;
    localparam int REGS_PER_CLASS = 2;
    localparam int REG_SIZE_OFS   = 0;
    localparam int REG_COUNT_OFS  = 1;

    // Parameter defaults for the top level
    localparam int NUM_CLASSES_DEF = 4;
    localparam int MAX_BLOCKS_DEF  = 16;

    // Commands carried in tuser
    localparam logic [CMD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 1'b1;

    // Result status codes
    typedef logic [STATUS_W-1:0] status_t;
    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NO_CLASS  = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_NOT_BLOCK = 2'd3;

endpackage

/* sv/scpa_div.sv */
// ============================================================================
// scpa_div - restoring divider, one quotient bit per cycle
// Divides a block offset by the block size; the quotient is known to fit in
// Q_W bits, so only Q_W compare/subtract steps are run.
// ============================================================================
module scpa_div #(
    parameter int DVD_W = 13,
    parameter int DSR_W = 8,
    parameter int Q_W   = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DSR_W-1:0] divisor,
    output logic             done,
    output logic [Q_W-1:0]   quotient,
    output logic [DVD_W-1:0] remainder
);

    localparam int SH_W = DSR_W + Q_W;
    localparam int CW   = (DVD_W > SH_W) ? DVD_W : SH_W;
    localparam int ST_W = $clog2(Q_W + 1);

    logic [DVD_W-1:0] rem_reg;
    logic [SH_W-1:0]  dsr_reg;
    logic [Q_W-1:0]   q_reg;
    logic [ST_W-1:0]  step_reg;
    logic             busy_reg;
    logic             done_reg;
    logic             ge;

    // Trial subtract of the shifted divisor
    assign ge = CW'(rem_reg) >= CW'(dsr_reg);

    // Control: step counter and completion pulse
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= ST_W'(Q_W);
            end else if (busy_reg) begin
                step_reg <= step_reg - ST_W'(1);
                if (step_reg == ST_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath: partial remainder, shifted divisor, quotient bits
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= dividend;
            dsr_reg <= SH_W'(divisor) << (Q_W - 1);
            q_reg   <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= DVD_W'(CW'(rem_reg) - CW'(dsr_reg));
            end
            dsr_reg <= dsr_reg >> 1;
            q_reg   <= (q_reg << 1) | Q_W'(ge);
        end
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = rem_reg;

endmodule

/* sv/size_class_pool_allocator.sv */
// ============================================================================
// size_class_pool_allocator - fixed-block allocator over up to four size classes
// Classes lie back to back in one pool; allocate claims the lowest free block
// of the class whose block size matches, free releases the block at an address.
// Allocate walks the classes to the matched one, picks in S_PICK, registers in S_OUT.
// Free walks one class per cycle; a class whose range holds the address adds a
// divide (at most one such class); an exact one goes to S_CLR, then S_OUT.
// One item in flight: the next request is taken the cycle after the result is
// registered.
// The in-use bitmap is one memory word per class, read-modify-write.
// Reset: configuration registers zero (every class disabled), all blocks free at once.
// ============================================================================
module size_class_pool_allocator #(
    parameter int NUM_CLASSES = scpa_pkg::NUM_CLASSES_DEF,
    parameter int MAX_BLOCKS  = scpa_pkg::MAX_BLOCKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Configuration write channel
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [scpa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scpa_pkg::CFG_DATA_W-1:0]     cfg_data,
    // Request stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [scpa_pkg::S_TDATA_W-1:0]      s_tdata,  // request_size, free_address
    input  logic [scpa_pkg::CMD_W-1:0]          s_tuser,  // command
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [scpa_pkg::M_TDATA_W-1:0]      m_tdata   // block_address, status
);

    import scpa_pkg::*;

    localparam int K_W    = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int B_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(MAX_BLOCKS + 1);
    localparam int SPAN_W = SIZE_W + CNT_W;
    localparam int CW     = (ADDR_W > SPAN_W) ? ADDR_W : SPAN_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;
    localparam logic [2:0] S_PICK  = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_CLR   = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [2:0]            state_reg, state_next;
    logic [SIZE_W-1:0]     req_reg, req_next;
    logic [ADDR_W-1:0]     faddr_reg, faddr_next;
    logic [K_W-1:0]        k_reg, k_next;
    logic [ADDR_W-1:0]     base_reg, base_next;
    logic [ADDR_W-1:0]     res_addr_reg, res_addr_next;
    status_t               res_status_reg, res_status_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    status_t               out_status_reg, out_status_next;
    logic                  m_tvalid_reg, m_tvalid_next;

    logic [SIZE_W-1:0]     cls_size_reg  [NUM_CLASSES];
    logic [CNT_REG_W-1:0]  cls_count_reg [NUM_CLASSES];

    // In-use bitmap memory, one word per class
    logic [MAX_BLOCKS-1:0] bit_mem [NUM_CLASSES];
    logic [NUM_CLASSES-1:0] mem_valid_reg;
    logic [MAX_BLOCKS-1:0] mem_q_reg;
    logic                  mem_q_valid_reg;
    logic                  rd_en, wr_en;
    logic [MAX_BLOCKS-1:0] wr_data;
    logic [MAX_BLOCKS-1:0] word;

    logic [SIZE_W-1:0]     size_k;
    logic [CNT_W-1:0]      eff_k;
    logic [SPAN_W-1:0]     span;
    logic [ADDR_W-1:0]     base_adv;
    logic [ADDR_W-1:0]     offset;
    logic                  in_range;
    logic                  last_k;
    logic                  pick_found;
    logic [B_W-1:0]        pick_b;
    logic [ADDR_W-1:0]     alloc_addr;

    logic                  div_start;
    logic                  div_done;
    logic [B_W-1:0]        div_q;
    logic [SPAN_W-1:0]     div_rem;

    // Configuration registers; classes without registers stay disabled
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                cls_size_reg[k]  <= '0;
                cls_count_reg[k] <= '0;
            end
        end else if (cfg_valid && cfg_ready) begin
            for (int k = 0; k < NUM_CLASSES; k++) begin
                if (k < CFG_CLASSES) begin
                    if (cfg_index == CFG_IDX_W'(REGS_PER_CLASS * k + REG_SIZE_OFS)) begin
                        cls_size_reg[k] <= cfg_data[SIZE_W-1:0];
                    end
                    if (cfg_index == CFG_IDX_W'(REGS_PER_CLASS * k + REG_COUNT_OFS)) begin
                        cls_count_reg[k] <= cfg_data[CNT_REG_W-1:0];
                    end
                end
            end
        end
    end

    // Bitmap memory: one read port, one write port, registered read data
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            bit_mem[k_reg] <= wr_data;
        end
        if (rd_en) begin
            mem_q_reg <= bit_mem[k_reg];
        end
    end

    // Per-word valid bits: an unwritten word reads as all blocks free
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mem_valid_reg   <= '0;
            mem_q_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                mem_valid_reg[k_reg] <= 1'b1;
            end
            if (rd_en) begin
                mem_q_valid_reg <= mem_valid_reg[k_reg];
            end
        end
    end

    assign word = mem_q_valid_reg ? mem_q_reg : '0;

    // Current class: size, clamped count, span and running base
    always_comb begin
        size_k = cls_size_reg[k_reg];
        if (32'(cls_count_reg[k_reg]) > 32'(MAX_BLOCKS)) begin
            eff_k = CNT_W'(MAX_BLOCKS);
        end else begin
            eff_k = CNT_W'(cls_count_reg[k_reg]);
        end
    end

    assign span     = SPAN_W'(size_k) * SPAN_W'(eff_k);
    assign base_adv = base_reg + ADDR_W'(span);
    assign offset   = faddr_reg - base_reg;
    assign in_range = (size_k != '0) && (CW'(offset) < CW'(span));
    assign last_k   = (k_reg == K_W'(NUM_CLASSES - 1));

    // Lowest free block within the class count
    always_comb begin
        pick_found = 1'b0;
        pick_b     = '0;
        for (int b = MAX_BLOCKS - 1; b >= 0; b--) begin
            if (!word[b] && (32'(b) < 32'(eff_k))) begin
                pick_found = 1'b1;
                pick_b     = B_W'(b);
            end
        end
    end

    assign alloc_addr = base_reg + ADDR_W'((B_W + SIZE_W)'(pick_b) * (B_W + SIZE_W)'(size_k));

    // Offset-to-block divider for free
    scpa_div #(
        .DVD_W (SPAN_W),
        .DSR_W (SIZE_W),
        .Q_W   (B_W)
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (SPAN_W'(offset)),
        .divisor   (size_k),
        .done      (div_done),
        .quotient  (div_q),
        .remainder (div_rem)
    );

    // Sequencer
    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        faddr_next      = faddr_reg;
        k_next          = k_reg;
        base_next       = base_reg;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        m_tvalid_next   = m_tvalid_reg;
        rd_en           = 1'b0;
        wr_en           = 1'b0;
        wr_data         = word;
        div_start       = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    req_next   = s_tdata[SIZE_W-1:0];
                    faddr_next = s_tdata[SIZE_W+ADDR_W-1:SIZE_W];
                    k_next     = '0;
                    base_next  = '0;
                    state_next = (s_tuser == CMD_ALLOC) ? S_ALLOC : S_SCAN;
                end
            end
            S_ALLOC: begin
                if (size_k != '0 && size_k == req_reg) begin
                    rd_en      = 1'b1;
                    state_next = S_PICK;
                end else if (last_k) begin
                    res_addr_next   = '0;
                    res_status_next = ST_NO_CLASS;
                    state_next      = S_OUT;
                end else begin
                    k_next    = k_reg + K_W'(1);
                    base_next = base_adv;
                end
            end
            S_PICK: begin
                if (pick_found) begin
                    wr_en           = 1'b1;
                    wr_data         = word | (MAX_BLOCKS'(1) << pick_b);
                    res_addr_next   = alloc_addr;
                    res_status_next = ST_OK;
                end else begin
                    res_addr_next   = '0;
                    res_status_next = ST_FULL;
                end
                state_next = S_OUT;
            end
            S_SCAN: begin
                if (in_range) begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end else if (last_k) begin
                    res_addr_next   = '0;
                    res_status_next = ST_NOT_BLOCK;
                    state_next      = S_OUT;
                end else begin
                    k_next    = k_reg + K_W'(1);
                    base_next = base_adv;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    if (div_rem == '0) begin
                        rd_en      = 1'b1;
                        state_next = S_CLR;
                    end else if (last_k) begin
                        res_addr_next   = '0;
                        res_status_next = ST_NOT_BLOCK;
                        state_next      = S_OUT;
                    end else begin
                        k_next     = k_reg + K_W'(1);
                        base_next  = base_adv;
                        state_next = S_SCAN;
                    end
                end
            end
            S_CLR: begin
                wr_en           = 1'b1;
                wr_data         = word & ~(MAX_BLOCKS'(1) << div_q);
                res_addr_next   = '0;
                res_status_next = ST_OK;
                state_next      = S_OUT;
            end
            S_OUT: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next   = 1'b1;
                    out_addr_next   = res_addr_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        req_reg        <= req_next;
        faddr_reg      <= faddr_next;
        k_reg          <= k_next;
        base_reg       <= base_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
        out_addr_reg   <= out_addr_next;
        out_status_reg <= out_status_next;
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = M_TDATA_W'({out_status_reg, out_addr_reg});

endmodule
